/* rtl/core/yrc_pkg.sv */
// Shared types and constants for the packed 4:2:2 to RGB converter.
package yrc_pkg;

  // Configuration register
  localparam int unsigned CFG_W           = 11;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 11'd640;
  localparam int unsigned MAX_WIDTH_DEF   = 1024;

  // Q2.10 conversion coefficients
  localparam logic signed [12:0] K_Y  = 13'sd1192;
  localparam logic signed [12:0] K_RV = 13'sd1634;
  localparam logic signed [12:0] K_GU = 13'sd401;
  localparam logic signed [12:0] K_GV = 13'sd833;
  localparam logic signed [12:0] K_BU = 13'sd2065;

  // Offsets of the studio-range inputs
  localparam logic signed [8:0] Y_OFS = 9'sd16;
  localparam logic signed [8:0] C_OFS = 9'sd128;

  // Width of the products and sums inside a lane
  localparam int unsigned PROD_W = 22;

  // One RGB pixel, red in the lowest byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } yrc_pix_t;

  // Per-item control carried along the lanes
  typedef struct packed {
    logic two_pix;
    logic row_end;
  } yrc_ctrl_t;

  // One output beat as held in the merge stage
  typedef struct packed {
    yrc_pix_t pix;
    logic     last_of_pair;
    logic     row_end;
  } yrc_beat_t;

endpackage

/* rtl/core/yuyv_to_rgba_converter_top.sv */
// Top level of the packed 4:2:2 (YUYV) to RGB converter, BT.601 studio range.
//
// Usage:
//  - Slave stream: one beat per pixel pair, tdata = {V, Y1, U, Y0} with Y0 lowest.
//  - Master stream: one beat per RGB pixel, red in the lowest byte; tuser marks
//    the last pixel of an input pair, tlast marks the last pixel of a row.
//  - Config channel: writes frame_width (pixels per row, 2..MAX_WIDTH, may be
//    odd; out-of-range values saturate). Write only while the block is idle.
//  - A pair at the end of an odd-width row yields one pixel, with V taken as U.
//  - A pair passes the decode, product, saturation and merge registers before
//    its first pixel shows on the master side; the second follows once taken.
//  - Throughput: one output pixel per cycle while the receiver is ready, set by
//    the single-pixel master port; after a two-pixel pair the slave side waits
//    for its second beat to leave, and takes a one-pixel pair every cycle.
//  - Reset clears the column counter and all pipeline valids, and sets
//    frame_width to 640.
//  - When the receiver stalls, the merge stage holds its beats and the lane
//    pipeline stalls behind it; no data is lost or repeated.
module yuyv_to_rgba_converter_top #(
  parameter int unsigned MAX_WIDTH = yrc_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [yrc_pkg::CFG_W-1:0] cfg_data_i,
  // pixel pairs in
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [31:0]               s_axis_tdata_i,  // luma_first, chroma_blue,
                                                     // luma_second, chroma_red
  // pixels out
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [23:0]               m_axis_tdata_o,  // red, green, blue
  output logic                      m_axis_tuser_o,  // last_of_pair
  output logic                      m_axis_tlast_o   // row_end
);

  localparam int unsigned COLW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = ((WW > yrc_pkg::CFG_W) ? WW : yrc_pkg::CFG_W) + 2;
  localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] MINW_C = CMPW'(2);

  logic [yrc_pkg::CFG_W-1:0] frame_width_q;
  logic [COLW-1:0]           column_q, column_d;

  logic [CMPW-1:0] width_raw, width_eff, col_p1, col_p2;
  logic            single, end_two, accept, adv, merge_ready;

  logic [7:0] y0_in, u_in, y1_in, v_in;

  // decode stage
  logic               v1_q, v2_q, v3_q;
  logic [7:0]         y0_q, y1_q, u_q, ve_q;
  yrc_pkg::yrc_ctrl_t ctrl1_q, ctrl2_q, ctrl3_q, ctrl_d;
  yrc_pkg::yrc_pix_t  px0, px1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= yrc_pkg::FRAME_WIDTH_RST;
    end else if (cfg_valid_i) begin
      frame_width_q <= cfg_data_i;
    end
  end

  assign y0_in = s_axis_tdata_i[7:0];
  assign u_in  = s_axis_tdata_i[15:8];
  assign y1_in = s_axis_tdata_i[23:16];
  assign v_in  = s_axis_tdata_i[31:24];

  // Saturate the width and place the pair in the row
  always_comb begin
    width_raw = CMPW'(frame_width_q);
    if (width_raw < MINW_C) begin
      width_eff = MINW_C;
    end else if (width_raw > MAXW_C) begin
      width_eff = MAXW_C;
    end else begin
      width_eff = width_raw;
    end
    col_p1  = CMPW'(column_q) + CMPW'(1);
    col_p2  = CMPW'(column_q) + CMPW'(2);
    single  = (col_p1 >= width_eff);
    end_two = (col_p2 >= width_eff);
    ctrl_d.two_pix = !single;
    ctrl_d.row_end = single || end_two;
    column_d = (single || end_two) ? '0 : col_p2[COLW-1:0];
  end

  // The whole lane pipeline advances when its last stage is free
  assign adv             = !v3_q || merge_ready;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      if (accept) begin
        column_q <= column_d;
      end
      if (adv) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  // Hold the decoded samples and control alongside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      y0_q    <= y0_in;
      y1_q    <= y1_in;
      u_q     <= u_in;
      ve_q    <= single ? u_in : v_in;
      ctrl1_q <= ctrl_d;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl2_q;
    end
  end

  yrc_lane u_lane0 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .luma_i (y0_q),
    .cb_i   (u_q),
    .cr_i   (ve_q),
    .pix_o  (px0)
  );

  yrc_lane u_lane1 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .luma_i (y1_q),
    .cb_i   (u_q),
    .cr_i   (ve_q),
    .pix_o  (px1)
  );

  yrc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (v3_q),
    .ctrl_i          (ctrl3_q),
    .px0_i           (px0),
    .px1_i           (px1),
    .ready_o         (merge_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* rtl/core/yrc_lane.sv */
// One conversion lane: YUV sample to saturated RGB in two register stages.
module yrc_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [7:0]        luma_i,
  input  logic [7:0]        cb_i,
  input  logic [7:0]        cr_i,
  output yrc_pkg::yrc_pix_t pix_o
);

  localparam int unsigned PW = yrc_pkg::PROD_W;

  localparam logic signed [PW-1:0] KY_W  = PW'(yrc_pkg::K_Y);
  localparam logic signed [PW-1:0] KRV_W = PW'(yrc_pkg::K_RV);
  localparam logic signed [PW-1:0] KGU_W = PW'(yrc_pkg::K_GU);
  localparam logic signed [PW-1:0] KGV_W = PW'(yrc_pkg::K_GV);
  localparam logic signed [PW-1:0] KBU_W = PW'(yrc_pkg::K_BU);

  // Floor by 10 bits and saturate to 0..255
  function automatic logic [7:0] sat_q10(input logic signed [PW-1:0] sum);
    logic [7:0] res;
    if (sum[PW-1]) begin
      res = 8'd0;
    end else if (|sum[PW-2:18]) begin
      res = 8'hFF;
    end else begin
      res = sum[17:10];
    end
    return res;
  endfunction

  logic signed [8:0]    c_s, d_s, e_s;
  logic signed [PW-1:0] c_w, d_w, e_w;

  logic signed [PW-1:0] base_q, rv_q, gu_q, gv_q, bu_q;
  logic signed [PW-1:0] sum_r, sum_g, sum_b;
  yrc_pkg::yrc_pix_t    pix_q;

  // Remove the offsets
  always_comb begin
    c_s = signed'({1'b0, luma_i}) - yrc_pkg::Y_OFS;
    d_s = signed'({1'b0, cb_i}) - yrc_pkg::C_OFS;
    e_s = signed'({1'b0, cr_i}) - yrc_pkg::C_OFS;
    c_w = PW'(c_s);
    d_w = PW'(d_s);
    e_w = PW'(e_s);
  end

  // Register the coefficient products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= c_w * KY_W;
      rv_q   <= e_w * KRV_W;
      gu_q   <= d_w * KGU_W;
      gv_q   <= e_w * KGV_W;
      bu_q   <= d_w * KBU_W;
    end
  end

  // Sum per channel
  always_comb begin
    sum_r = base_q + rv_q;
    sum_g = base_q - gu_q - gv_q;
    sum_b = base_q + bu_q;
  end

  // Register the saturated channels
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q.red   <= sat_q10(sum_r);
      pix_q.green <= sat_q10(sum_g);
      pix_q.blue  <= sat_q10(sum_b);
    end
  end

  assign pix_o = pix_q;

endmodule

/* rtl/core/yrc_merge.sv */
// Merge: sends an item's lane pixels one beat each; a one-pixel item sends only px0.
module yrc_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  yrc_pkg::yrc_ctrl_t ctrl_i,
  input  yrc_pkg::yrc_pix_t  px0_i,
  input  yrc_pkg::yrc_pix_t  px1_i,
  output logic               ready_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [23:0]        m_axis_tdata_o,  // red [7:0], green [15:8], blue [23:16]
  output logic               m_axis_tuser_o,  // last_of_pair
  output logic               m_axis_tlast_o   // row_end
);

  logic [1:0]         cnt_q, cnt_d;
  yrc_pkg::yrc_beat_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic               fire, load;

  assign fire    = (cnt_q != 2'd0) && m_axis_tready_i;
  assign ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i);
  assign load    = in_valid_i && ready_o;

  // Load a new item or advance the second beat to the head
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load) begin
      slot0_d.pix = px0_i;
      slot1_d.pix = px1_i;
      if (ctrl_i.two_pix) begin
        slot0_d.last_of_pair = 1'b0;
        slot0_d.row_end      = 1'b0;
        slot1_d.last_of_pair = 1'b1;
        slot1_d.row_end      = ctrl_i.row_end;
        cnt_d                = 2'd2;
      end else begin
        slot0_d.last_of_pair = 1'b1;
        slot0_d.row_end      = 1'b1;
        slot1_d.last_of_pair = 1'b1;
        slot1_d.row_end      = 1'b1;
        cnt_d                = 2'd1;
      end
    end else if (fire) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the beat payloads
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = slot0_q.pix;
  assign m_axis_tuser_o  = slot0_q.last_of_pair;
  assign m_axis_tlast_o  = slot0_q.row_end;

endmodule
